>>> rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; modules that use them have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SIFSA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("allocator assertion failed");
`define SIFSA_ASSERT_COMB(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("allocator invariant violated");
`else
`define SIFSA_ASSERT(label, prop)
`define SIFSA_ASSERT_COMB(label, expr)
`endif
`endif

>>> rtl/sifsa_pkg.sv
// Package for the separable input-first switch allocator.
// Holds sizes, word types and lane interface structs; depends on nothing.
`default_nettype none
package sifsa_pkg;
  localparam int unsigned PORT_CNT      = 5;
  localparam int unsigned NUM_VCS       = 4;
  localparam int unsigned OUT_PORT_BITS = 3;
  localparam int unsigned IN_PORT_BITS  = 3;
  localparam int unsigned VC_IDX_BITS   = 2;
  localparam int unsigned REQ_W         = 20;
  localparam int unsigned DEST_W        = 60;
  localparam int unsigned GV_W          = 5;
  localparam int unsigned GP_W          = 15;
  localparam int unsigned GVC_W         = 10;
  localparam int unsigned PORT_W = (PORT_CNT > 1) ? $clog2(PORT_CNT) : 1;
  localparam int unsigned VC_W   = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;

  typedef struct packed {
    logic [REQ_W-1:0]  request_mask;
    logic [DEST_W-1:0] request_out_ports;
    logic [REQ_W-1:0]  credit_ok_mask;
  } req_word_t;

  typedef struct packed {
    logic [GV_W-1:0]  grant_valid;
    logic [GP_W-1:0]  grant_in_ports;
    logic [GVC_W-1:0] grant_in_vcs;
  } gnt_word_t;

  // Level-1 result of one input port.
  typedef struct packed {
    logic                     has;
    logic [OUT_PORT_BITS-1:0] dest;
    logic [VC_W-1:0]          vc;
  } l1_t;

  // Level-2 result of one output port.
  typedef struct packed {
    logic              gnt;
    logic [PORT_W-1:0] port;
  } l2_t;
endpackage
`default_nettype wire

>>> rtl/sifsa_in_lane.sv
// Level-1 lane: picks one VC of an input port by least-recently-granted order.
// Depends on sifsa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sifsa_in_lane (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic [sifsa_pkg::NUM_VCS-1:0]                         req_i,
  input  logic [sifsa_pkg::NUM_VCS-1:0]                         cred_i,
  input  logic [sifsa_pkg::NUM_VCS-1:0][sifsa_pkg::OUT_PORT_BITS-1:0] dest_i,
  input  logic                                                  adv_i,
  input  logic                                                  gnt_i,
  output sifsa_pkg::l1_t                                        l1_o
);
  import sifsa_pkg::*;

  logic [VC_W-1:0] ord_q [NUM_VCS];
  logic [VC_W-1:0] ord_d [NUM_VCS];
  logic [NUM_VCS-1:0] elig;
  logic            found;
  logic [VC_W-1:0] pick;

  always_comb begin
    for (int v = 0; v < NUM_VCS; v++) begin
      elig[v] = req_i[v] & cred_i[v] &
                ({1'b0, dest_i[v]} < (OUT_PORT_BITS + 1)'(PORT_CNT));
    end
  end

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int k = 0; k < NUM_VCS; k++) begin
      if (!found && elig[ord_q[k]]) begin
        found = 1'b1;
        pick  = ord_q[k];
      end
    end
  end

  assign l1_o.has  = found;
  assign l1_o.vc   = pick;
  assign l1_o.dest = dest_i[pick];

  // The winner leaves its slot, everything behind it moves up one place.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < NUM_VCS - 1; i++) begin
      seen     = seen | (ord_q[i] == pick);
      ord_d[i] = seen ? ord_q[i+1] : ord_q[i];
    end
    ord_d[NUM_VCS-1] = pick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VCS; i++) ord_q[i] <= VC_W'(i);
    end else if (adv_i && gnt_i && found) begin
      for (int i = 0; i < NUM_VCS; i++) ord_q[i] <= ord_d[i];
    end
  end

  `SIFSA_ASSERT_COMB(a_pick_eligible, !found || elig[pick])
  `SIFSA_ASSERT(a_winner_to_back,
                (adv_i && gnt_i && found) |=> ord_q[NUM_VCS-1] == $past(pick))
endmodule
`default_nettype wire

>>> rtl/sifsa_out_lane.sv
// Level-2 lane: picks one input port for an output port and rotates it back.
// Depends on sifsa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sifsa_out_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sifsa_pkg::PORT_CNT-1:0] cand_i,
  input  logic                           adv_i,
  output sifsa_pkg::l2_t                 l2_o
);
  import sifsa_pkg::*;

  logic [PORT_W-1:0] ord_q [PORT_CNT];
  logic [PORT_W-1:0] ord_d [PORT_CNT];
  logic              found;
  logic [PORT_W-1:0] pick;

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int k = 0; k < PORT_CNT; k++) begin
      if (!found && cand_i[ord_q[k]]) begin
        found = 1'b1;
        pick  = ord_q[k];
      end
    end
  end

  assign l2_o.gnt  = found;
  assign l2_o.port = pick;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < PORT_CNT - 1; i++) begin
      seen     = seen | (ord_q[i] == pick);
      ord_d[i] = seen ? ord_q[i+1] : ord_q[i];
    end
    ord_d[PORT_CNT-1] = pick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORT_CNT; i++) ord_q[i] <= PORT_W'(i);
    end else if (adv_i && found) begin
      for (int i = 0; i < PORT_CNT; i++) ord_q[i] <= ord_d[i];
    end
  end

  `SIFSA_ASSERT_COMB(a_grant_iff_cand, found == (|cand_i))
endmodule
`default_nettype wire

>>> rtl/separable_input_first_switch_allocator_core.sv
// A word accepted at one edge shows its grants at the output the next cycle.
// One word per cycle unless stalled; all lanes and both priority updates settle in that cycle.
// A single output register decouples the sides: input stalls only while it is full and stalled.
// Reset: all VC and input-port orders return to index order, the output register empties.
// Depends on sifsa_pkg, sifsa_in_lane, sifsa_out_lane and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module separable_input_first_switch_allocator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sifsa_pkg::req_word_t in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sifsa_pkg::gnt_word_t out_word_o
);
  import sifsa_pkg::*;

  logic adv;
  l1_t  l1 [PORT_CNT];
  l2_t  l2 [PORT_CNT];
  logic [PORT_CNT-1:0] in_gnt;
  logic [PORT_CNT-1:0][PORT_CNT-1:0] cand;   // [output][input]
  gnt_word_t res;
  logic      out_valid_q, out_valid_d;
  gnt_word_t out_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign adv        = in_valid_i && !in_stall_o;

  for (genvar p = 0; p < PORT_CNT; p++) begin : g_in
    logic [NUM_VCS-1:0] req_v, cred_v;
    logic [NUM_VCS-1:0][OUT_PORT_BITS-1:0] dest_v;
    for (genvar v = 0; v < NUM_VCS; v++) begin : g_vc
      localparam int unsigned N = p * NUM_VCS + v;
      if (N < REQ_W && (N + 1) * OUT_PORT_BITS <= DEST_W) begin : g_on
        assign req_v[v]  = in_word_i.request_mask[N];
        assign cred_v[v] = in_word_i.credit_ok_mask[N];
        assign dest_v[v] = in_word_i.request_out_ports[N*OUT_PORT_BITS +: OUT_PORT_BITS];
      end else begin : g_off
        assign req_v[v]  = 1'b0;
        assign cred_v[v] = 1'b0;
        assign dest_v[v] = '0;
      end
    end

    sifsa_in_lane u_in (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req_v),
      .cred_i (cred_v),
      .dest_i (dest_v),
      .adv_i  (adv),
      .gnt_i  (in_gnt[p]),
      .l1_o   (l1[p])
    );
  end

  for (genvar o = 0; o < PORT_CNT; o++) begin : g_out
    for (genvar p = 0; p < PORT_CNT; p++) begin : g_cand
      assign cand[o][p] = l1[p].has && (l1[p].dest == OUT_PORT_BITS'(o));
    end

    sifsa_out_lane u_out (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cand_i (cand[o]),
      .adv_i  (adv),
      .l2_o   (l2[o])
    );
  end

  // Merge: tell each input port whether its level-1 winner got an output, and pack grants.
  always_comb begin
    in_gnt = '0;
    res    = '0;
    for (int o = 0; o < PORT_CNT; o++) begin
      if (l2[o].gnt) begin
        res.grant_valid[o] = 1'b1;
        res.grant_in_ports[o*IN_PORT_BITS +: IN_PORT_BITS] = IN_PORT_BITS'(l2[o].port);
        res.grant_in_vcs[o*VC_IDX_BITS +: VC_IDX_BITS] = VC_IDX_BITS'(l1[l2[o].port].vc);
      end
      for (int p = 0; p < PORT_CNT; p++) begin
        if (l2[o].gnt && (l2[o].port == PORT_W'(p))) in_gnt[p] = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `SIFSA_ASSERT_COMB(a_stall_only_when_full, !in_stall_o || out_valid_q)
  `SIFSA_ASSERT(a_no_request_no_grant,
                (adv && (in_word_i.request_mask == '0)) |=> out_q.grant_valid == '0)
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the separable input-first switch allocator core: drives request words,
// predicts every grant word in a scoreboard class and checks each one as it leaves.
// Depends on sifsa_pkg and separable_input_first_switch_allocator_core.

class grant_tracker;
  // VC order per input port and input-port order per output port, highest priority first.
  int vc_order[sifsa_pkg::PORT_CNT][$];
  int port_order[sifsa_pkg::PORT_CNT][$];
  sifsa_pkg::gnt_word_t expected_grants[$];
  int failures;

  function new();
    for (int p = 0; p < sifsa_pkg::PORT_CNT; p++) begin
      for (int k = 0; k < sifsa_pkg::NUM_VCS; k++) vc_order[p].insert(vc_order[p].size(), k);
      for (int k = 0; k < sifsa_pkg::PORT_CNT; k++) begin
        port_order[p].insert(port_order[p].size(), k);
      end
    end
    failures = 0;
  endfunction

  // Runs one allocation round on an accepted request word and queues its grant word.
  function void note_request(sifsa_pkg::req_word_t w);
    bit has_pick[sifsa_pkg::PORT_CNT];
    int pick_vc[sifsa_pkg::PORT_CNT];
    int pick_dest[sifsa_pkg::PORT_CNT];
    int n, c, d, pos;
    sifsa_pkg::gnt_word_t g;
    g = '0;
    // Input stage: all picks use the VC orders as they stood before this round.
    for (int p = 0; p < sifsa_pkg::PORT_CNT; p++) begin
      has_pick[p] = 1'b0;
      pick_vc[p] = 0;
      pick_dest[p] = 0;
      for (int k = 0; k < sifsa_pkg::NUM_VCS; k++) begin
        c = vc_order[p][k];
        n = p * sifsa_pkg::NUM_VCS + c;
        d = int'(w.request_out_ports[n*sifsa_pkg::OUT_PORT_BITS +: sifsa_pkg::OUT_PORT_BITS]);
        if (!has_pick[p] && w.request_mask[n] && w.credit_ok_mask[n] &&
            d < sifsa_pkg::PORT_CNT) begin
          has_pick[p] = 1'b1;
          pick_vc[p] = c;
          pick_dest[p] = d;
        end
      end
    end
    // Output stage: the winning input port and its VC both drop to lowest priority.
    for (int o = 0; o < sifsa_pkg::PORT_CNT; o++) begin
      for (int k = 0; k < sifsa_pkg::PORT_CNT; k++) begin
        c = port_order[o][k];
        if (has_pick[c] && pick_dest[c] == o) begin
          g.grant_valid[o] = 1'b1;
          g.grant_in_ports[o*sifsa_pkg::IN_PORT_BITS +: sifsa_pkg::IN_PORT_BITS] =
            c[sifsa_pkg::IN_PORT_BITS-1:0];
          g.grant_in_vcs[o*sifsa_pkg::VC_IDX_BITS +: sifsa_pkg::VC_IDX_BITS] =
            pick_vc[c][sifsa_pkg::VC_IDX_BITS-1:0];
          port_order[o].delete(k);
          port_order[o].insert(port_order[o].size(), c);
          pos = 0;
          for (int i = 0; i < sifsa_pkg::NUM_VCS; i++) begin
            if (vc_order[c][i] == pick_vc[c]) pos = i;
          end
          vc_order[c].delete(pos);
          vc_order[c].insert(vc_order[c].size(), pick_vc[c]);
          break;
        end
      end
    end
    expected_grants.insert(expected_grants.size(), g);
  endfunction

  function void check_grant(sifsa_pkg::gnt_word_t g);
    sifsa_pkg::gnt_word_t e;
    if (expected_grants.size() == 0) begin
      $error("grant word %h arrived with no word pending", g);
      failures++;
      return;
    end
    e = expected_grants.pop_front();
    if (g.grant_valid !== e.grant_valid) begin
      $error("grant_valid: expected %h, actual %h", e.grant_valid, g.grant_valid);
      failures++;
    end
    if (g.grant_in_ports !== e.grant_in_ports) begin
      $error("grant_in_ports: expected %h, actual %h", e.grant_in_ports, g.grant_in_ports);
      failures++;
    end
    if (g.grant_in_vcs !== e.grant_in_vcs) begin
      $error("grant_in_vcs: expected %h, actual %h", e.grant_in_vcs, g.grant_in_vcs);
      failures++;
    end
  endfunction
endclass

module tb_top;
  import sifsa_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int RANDOM_WORDS = 640;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_stall_i = 1'b0;
  req_word_t in_word_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  gnt_word_t out_word_o;

  grant_tracker tracker = new();
  int idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  separable_input_first_switch_allocator_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Scoreboard updates and the watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_request(in_word_i);
      if (out_valid_o && !out_stall_i) tracker.check_grant(out_word_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offers one request word after a gap and returns at the edge that accepts it.
  task automatic send_request(req_word_t w, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_word_i = w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Grant receiver: random stalls, two long hold-offs to fill the block, and a stall-free stretch.
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken == 120 || taken == 420) gap = HOLD_CYCLES;
      else if (taken >= 300 && taken < 380) gap = 0;
      else gap = $urandom_range(0, 4);
      repeat (gap) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
      end
      @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    req_word_t directed[$];
    req_word_t w;
    logic [DEST_W-1:0] dests;
    int mode;
    int idx;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Nothing requested, then every VC asking for a nonexistent output.
    w = '0;
    directed.insert(directed.size(), w);
    w = '1;
    directed.insert(directed.size(), w);
    // Every VC fights for output 0, so both orders rotate.
    w.request_out_ports = '0;
    repeat (4) directed.insert(directed.size(), w);
    // Requests everywhere but no credit anywhere.
    w.request_out_ports = {20{3'd4}};
    w.credit_ok_mask = '0;
    directed.insert(directed.size(), w);
    // Each input port owns one output, so every level-1 winner is granted.
    for (int n = 0; n < PORT_CNT * NUM_VCS; n++) dests[n*3 +: 3] = OUT_PORT_BITS'(n / NUM_VCS);
    w.request_mask = '1;
    w.credit_ok_mask = '1;
    w.request_out_ports = dests;
    repeat (4) directed.insert(directed.size(), w);
    // Lone requests from the highest and the lowest VC number.
    w.request_mask = 20'h80000;
    w.request_out_ports = {20{3'd4}};
    directed.insert(directed.size(), w);
    w.request_mask = 20'h00001;
    w.request_out_ports = '0;
    directed.insert(directed.size(), w);
    // Mix of legal and out-of-range outputs.
    for (int n = 0; n < PORT_CNT * NUM_VCS; n++) dests[n*3 +: 3] = OUT_PORT_BITS'(n % 8);
    w.request_mask = '1;
    w.request_out_ports = dests;
    directed.insert(directed.size(), w);
    // Credit on every other VC only.
    for (int n = 0; n < PORT_CNT * NUM_VCS; n++) dests[n*3 +: 3] = OUT_PORT_BITS'(n % PORT_CNT);
    w.request_out_ports = dests;
    w.credit_ok_mask = 20'h55555;
    repeat (2) directed.insert(directed.size(), w);
    // Input port p aims at output PORT_CNT-1-p.
    for (int n = 0; n < PORT_CNT * NUM_VCS; n++) begin
      dests[n*3 +: 3] = OUT_PORT_BITS'(PORT_CNT - 1 - n / NUM_VCS);
    end
    w.request_out_ports = dests;
    w.credit_ok_mask = '1;
    repeat (2) directed.insert(directed.size(), w);

    foreach (directed[i]) send_request(directed[i], $urandom_range(0, 4));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      mode = $urandom_range(0, 99);
      w.request_mask = REQ_W'((mode < 40) ? ($urandom | $urandom) : $urandom);
      w.credit_ok_mask = REQ_W'((mode < 80) ? ($urandom | $urandom) : $urandom);
      if (mode < 80) begin
        // Mostly legal destinations with an occasional out-of-range one, heavily contended in a share of the words.
        for (int n = 0; n < PORT_CNT * NUM_VCS; n++) begin
          dests[n*3 +: 3] = OUT_PORT_BITS'((mode < 20) ? $urandom_range(0, 1) :
                                                        $urandom_range(0, 4));
        end
        if ($urandom_range(0, 7) == 0) begin
          idx = int'($urandom_range(0, PORT_CNT * NUM_VCS - 1));
          dests[idx*3 +: 3] = OUT_PORT_BITS'($urandom_range(5, 7));
        end
      end else begin
        dests = DEST_W'({$urandom, $urandom});
      end
      w.request_out_ports = dests;
      send_request(w, (i >= 280 && i < 360) ? 0 : $urandom_range(0, 4));
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (tracker.expected_grants.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
